// ===== rtl/cursor_sequence_store_core_assert.svh =====
// Assertion macros for the cursor sequence store.
// Both sample on the rising clock edge and stay quiet while reset is high.
`ifndef CURSOR_SEQUENCE_STORE_CORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CSEQ_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cursor sequence store: check failed");

// Next-cycle implication.
`define CSEQ_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cursor sequence store: check failed");

`endif

// ===== rtl/cseq_pkg.sv =====
package cseq_pkg;

   localparam int DEPTH_DEF       = 32;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int CMD_W           = 3;
   localparam int STATUS_W        = 2;
   // wide enough for any position at the largest supported depth (1024)
   localparam int CTL_POS_W       = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESTART = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_ATTACH  = 3'd3,
      CMD_REMOVE  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_ITEM = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_OPEN,
      SHIFT_CLOSE
   } shift_type;

   typedef struct packed {
      shift_type            op;
      logic [CTL_POS_W-1:0] pos;
   } cell_ctl_type;

endpackage

// ===== rtl/cseq_req_if.sv =====
interface cseq_req_if #(
   parameter int VW = cseq_pkg::VALUE_WIDTH_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic [cseq_pkg::CMD_W-1:0]  cmd;
   logic [VW-1:0]               value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

// ===== rtl/cseq_rsp_if.sv =====
interface cseq_rsp_if #(
   parameter int CW = 6,
   parameter int VW = cseq_pkg::VALUE_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [CW-1:0]                 count;
   logic [CW-1:0]                 cursor;
   logic                          has_item;
   logic [VW-1:0]                 current_value;
   logic [cseq_pkg::STATUS_W-1:0] status;

   modport source (output valid, count, cursor, has_item, current_value, status,
                   input ready);
   modport sink   (input valid, count, cursor, has_item, current_value, status,
                   output ready);
endinterface

// ===== rtl/cseq_cell.sv =====
module cseq_cell #(
   parameter int INDEX = 0,
   parameter int VW    = cseq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  cseq_pkg::cell_ctl_type ctl,
   input  logic [VW-1:0]          value,
   input  logic [VW-1:0]          left_data,
   input  logic [VW-1:0]          right_data,
   output logic [VW-1:0]          data
);

   localparam logic [cseq_pkg::CTL_POS_W-1:0] MY_POS = cseq_pkg::CTL_POS_W'(INDEX);

   logic [VW-1:0] data_ff;
   logic [VW-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         cseq_pkg::SHIFT_OPEN: begin
            // take from the left above the gap, load the new value into it
            if (MY_POS > ctl.pos) begin
               data_in = left_data;
            end else if (MY_POS == ctl.pos) begin
               data_in = value;
            end
         end
         cseq_pkg::SHIFT_CLOSE: begin
            if (MY_POS >= ctl.pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/cursor_sequence_store_core.sv =====
// Cursor sequence store: an ordered list of up to DEPTH values with a cursor.
//
// req_ch carries one request per valid/ready handshake: a command (restart,
// advance, insert before, attach after, remove current) and a value used by
// insert and attach. rsp_ch returns exactly one response per request with the
// count, cursor, current-item flag, value at the cursor and a status code.
//
// Entries live in a row of cells; an insert or remove shifts every affected
// cell at once in the cycle the request is accepted, whatever its position.
// Once the response register is free, the response is formed from the updated
// cells and loaded into the output register. A new request is not taken
// until the previous response has been formed, because the cursor entry is
// read back from the updated row before the next request may change it.
//
// Reset clears count, cursor and all handshake state; cell contents are not
// cleared and are only ever read below the count. While the receiver stalls
// the response register holds, the finished request waits behind it, and
// req_ch.ready stays low until the response moves out.
`include "cursor_sequence_store_core_assert.svh"

module cursor_sequence_store_core #(
   parameter int DEPTH       = cseq_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = cseq_pkg::VALUE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   cseq_req_if.sink   req_ch,
   cseq_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // list state
   logic [CW-1:0] count_ff,  count_in;
   logic [CW-1:0] cursor_ff, cursor_in;

   // request done, response not yet formed
   logic                 pend_ff, pend_in;
   cseq_pkg::status_type status_ff, status_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rsp_count_ff, rsp_cursor_ff;
   logic                 rsp_has_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   cseq_pkg::status_type rsp_status_ff;

   logic                  accept;
   logic                  out_free;
   logic                  has_cur;
   logic                  full;
   cseq_pkg::cell_ctl_type ctl;
   cseq_pkg::status_type   req_status;
   logic [CW-1:0]          req_count, req_cursor;
   logic [CW-1:0]          slot_pos;
   logic [VALUE_WIDTH-1:0] cell_data [DEPTH];

   assign has_cur  = cursor_ff < count_ff;
   assign full     = count_ff == FULL_COUNT;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && req_ch.ready;

   // hold off new requests until the previous one has its response formed
   assign req_ch.ready = !pend_ff;

   // decode the command against the current state
   always_comb begin
      req_count  = count_ff;
      req_cursor = cursor_ff;
      req_status = cseq_pkg::ST_DONE;
      slot_pos   = '0;
      ctl.op     = cseq_pkg::SHIFT_HOLD;
      case (req_ch.cmd)
         cseq_pkg::CMD_RESTART: begin
            req_cursor = '0;
         end
         cseq_pkg::CMD_ADVANCE: begin
            if (has_cur) begin
               req_cursor = cursor_ff + 1'b1;
            end else begin
               req_status = cseq_pkg::ST_NO_ITEM;
            end
         end
         cseq_pkg::CMD_INSERT: begin
            if (full) begin
               req_status = cseq_pkg::ST_FULL;
            end else begin
               // no current item: new entry goes to the front
               slot_pos   = has_cur ? cursor_ff : '0;
               req_cursor = slot_pos;
               req_count  = count_ff + 1'b1;
               ctl.op     = cseq_pkg::SHIFT_OPEN;
            end
         end
         cseq_pkg::CMD_ATTACH: begin
            if (full) begin
               req_status = cseq_pkg::ST_FULL;
            end else begin
               // no current item: new entry goes to the end
               slot_pos   = has_cur ? cursor_ff + 1'b1 : count_ff;
               req_cursor = slot_pos;
               req_count  = count_ff + 1'b1;
               ctl.op     = cseq_pkg::SHIFT_OPEN;
            end
         end
         cseq_pkg::CMD_REMOVE: begin
            if (has_cur) begin
               slot_pos  = cursor_ff;
               req_count = count_ff - 1'b1;
               ctl.op    = cseq_pkg::SHIFT_CLOSE;
            end else begin
               req_status = cseq_pkg::ST_NO_ITEM;
            end
         end
         default: begin
            req_status = cseq_pkg::ST_DONE;
         end
      endcase
      // drop the shift unless the request is really taken
      if (!accept) begin
         ctl.op = cseq_pkg::SHIFT_HOLD;
      end
      ctl.pos = cseq_pkg::CTL_POS_W'(slot_pos);
   end

   // row of cells; the edges see the new value and their own contents
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_d;
      logic [VALUE_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = req_ch.value;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      cseq_cell #(
         .INDEX (i),
         .VW    (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .value      (req_ch.value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i])
      );
   end

   // advance list state on acceptance; retire the pending request when the
   // response register can take it
   always_comb begin
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      status_in    = status_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && out_free) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (accept) begin
         count_in  = req_count;
         cursor_in = req_cursor;
         status_in = req_status;
         pend_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: status of the pending request and the response
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (pend_ff && out_free) begin
         rsp_count_ff  <= count_ff;
         rsp_cursor_ff <= cursor_ff;
         rsp_has_ff    <= has_cur;
         rsp_value_ff  <= has_cur ? cell_data[cursor_ff[IW-1:0]] : '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.count         = rsp_count_ff;
   assign rsp_ch.cursor        = rsp_cursor_ff;
   assign rsp_ch.has_item      = rsp_has_ff;
   assign rsp_ch.current_value = rsp_value_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // cursor never runs past the stored entries
   `CSEQ_CHECK_NOW(a_cursor_in_range, 1'b1, cursor_ff <= count_ff)
   // count never exceeds the row of cells
   `CSEQ_CHECK_NOW(a_count_in_range, 1'b1, count_ff <= FULL_COUNT)
   // an accepted request always leaves a pending response behind it
   `CSEQ_CHECK_NEXT(a_accept_pends, accept, pend_ff)
   // a response with no current item carries a zero value
   `CSEQ_CHECK_NOW(a_empty_value_zero, rsp_valid_ff && !rsp_has_ff, rsp_value_ff == '0)

endmodule
